// ===== design/crossfaded_chirp_sample_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Crossfaded chirp generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CROSSFADED_CHIRP_SAMPLE_GENERATOR_DEFINES_SVH
`define CROSSFADED_CHIRP_SAMPLE_GENERATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define CCSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define CCSG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/ccsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Crossfaded chirp generator package
// Shared widths, register codes, reset values and the sine table function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccsg_pkg;

  localparam int T_W     = 20;   // sample index
  localparam int PHASE_W = 48;   // phase, fraction of a turn
  localparam int SINE_W  = 18;   // Q16 sine, -65536..65536
  localparam int CFG_W   = 32;
  localparam int BS_W    = 15;
  localparam int LEN_W   = 21;
  localparam int ADDR_W  = 2;

  localparam logic [31:0]      RST_CHIRP_RATE   = 32'd72365000;
  localparam logic [31:0]      RST_BASE_FREQ    = 32'd10713117;
  localparam logic [BS_W-1:0]  RST_BLOCK_SIZE   = 15'd64;
  localparam logic [LEN_W-1:0] RST_TOTAL_LENGTH = 21'd220500;

  localparam logic [14:0] FULL_SCALE = 15'd32767;

  localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DENS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef enum logic [ADDR_W-1:0] {
    REG_CHIRP_RATE   = 2'd0,
    REG_BASE_FREQ    = 2'd1,
    REG_BLOCK_SIZE   = 2'd2,
    REG_TOTAL_LENGTH = 2'd3
  } cfg_reg_e;

  // Live register values seen by the datapath
  typedef struct packed {
    logic [31:0]      chirp_rate;
    logic [31:0]      base_freq;
    logic [BS_W-1:0]  block_size;   // zero already mapped to one
    logic [LEN_W-1:0] total_length; // already clamped to capacity
  } cfg_t;

  // Entry k of a full-wave table of 2^sb entries, Q16. Elaboration only.
  function automatic logic signed [SINE_W-1:0] sine_entry(input logic [31:0] k,
                                                          input int sb);
    logic [63:0] f;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] s;
    logic [63:0] v;
    f = {32'd0, k} << (32 - sb);
    q = (f >> 30) & 64'd3;
    r = f & (Q30_ONE - 64'd1);
    if (q[0]) r = Q30_ONE - r;
    th = (r * HALF_PI_Q30) >> 30;
    t2 = (th * th) >> 30;
    s  = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      s = Q30_ONE - ((t2 * s) >> 30) / TAYLOR_DENS[i];
    end
    v = (th * s) >> 30;
    v = (v + 64'd8192) >> 14;
    sine_entry = q[1] ? -$signed(SINE_W'(v)) : $signed(SINE_W'(v));
  endfunction

endpackage

// ===== design/ccsg_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; partial remainder may start nonzero (< den).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsg_div_pipe #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 15,
  parameter int PAY_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [PAY_W-1:0] pay_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [PAY_W-1:0] pay_o
);

  logic             v_q   [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];  // numerator bits out the top, quotient in the bottom
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [PAY_W-1:0] pay_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic             v_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [PAY_W-1:0] pay_in;
    logic [DEN_W:0]   trial;
    logic             fit;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign nq_in  = num_i;
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign fit   = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq_in[NUM_W-2:0], fit};
        rem_q[k] <= fit ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        den_q[k] <= den_in;
        pay_q[k] <= pay_in;
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quo_o   = nq_q[NUM_W-1];
  assign rem_o   = rem_q[NUM_W-1];
  assign pay_o   = pay_q[NUM_W-1];

endmodule

// ===== design/ccsg_phase.sv =====
// ----------------------------------------------------------------------------
// Chirp phase pipeline
// Segment bounds, start phase and both slopes, then the two table indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsg_phase #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  ccsg_pkg::cfg_t              cfg_i,
  input  logic [ccsg_pkg::T_W-1:0]    t_i,
  input  logic [ccsg_pkg::BS_W-1:0]   d_i,
  input  logic                        oor_i,
  output logic                        valid_o,
  output logic [ccsg_pkg::BS_W-1:0]   d_o,
  output logic [ccsg_pkg::BS_W-1:0]   span_o,
  output logic [$clog2(SINE_ENTRIES)-1:0] idx_l_o,
  output logic [$clog2(SINE_ENTRIES)-1:0] idx_r_o,
  output logic                        oor_o
);

  localparam int SB = $clog2(SINE_ENTRIES);
  localparam int PW = ccsg_pkg::PHASE_W;
  localparam int TW = ccsg_pkg::T_W;
  localparam int BW = ccsg_pkg::BS_W;
  localparam int LW = ccsg_pkg::LEN_W;
  localparam int NS = 6;

  logic [NS-1:0] v_q;
  logic [BW-1:0] d_q    [NS];
  logic [BW-1:0] span_q [NS];
  logic          oor_q  [NS];

  logic [PW-1:0] a48;
  logic [PW-1:0] b48;
  assign a48 = {{(PW-32){cfg_i.chirp_rate[31]}}, cfg_i.chirp_rate};
  assign b48 = {cfg_i.base_freq, 16'd0};

  // stage 1: segment start and length
  logic [TW-1:0] t0_d;
  logic [LW-1:0] t1c;
  logic [LW-1:0] t1;
  logic [BW-1:0] span_d;
  assign t0_d   = t_i - {{(TW-BW){1'b0}}, d_i};
  assign t1c    = {1'b0, t0_d} + {{(LW-BW){1'b0}}, cfg_i.block_size};
  assign t1     = (t1c > cfg_i.total_length) ? cfg_i.total_length : t1c;
  assign span_d = BW'(t1 - {1'b0, t0_d});

  // per-stage payload
  logic [TW-1:0] t0_1_q, t0_2_q, t0_3_q;
  logic [PW-1:0] at0_q, aspan_2_q, aspan_3_q;
  logic [PW-1:0] g_q, fl_3_q, fl_4_q, fr_q;
  logic [PW-1:0] w0_4_q, w0_5_q, pl_q, pr_q;
  logic [SB-1:0] idx_l_q, idx_r_q;

  logic [PW-1:0] ph_l, ph_r;
  assign ph_l = w0_5_q + pl_q;
  assign ph_r = w0_5_q + pr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1
      t0_1_q    <= t0_d;
      d_q[0]    <= d_i;
      span_q[0] <= span_d;
      oor_q[0]  <= oor_i;
      // stage 2: a*t0, a*span (mod 2^48)
      at0_q     <= PW'(a48 * t0_1_q);
      aspan_2_q <= PW'(a48 * span_q[0]);
      t0_2_q    <= t0_1_q;
      // stage 3: g = a*t0 + b, left slope 2*a*t0 + b
      g_q       <= at0_q + b48;
      fl_3_q    <= {at0_q[PW-2:0], 1'b0} + b48;
      aspan_3_q <= aspan_2_q;
      t0_3_q    <= t0_2_q;
      // stage 4: start phase t0*(a*t0 + b), chord slope
      w0_4_q    <= PW'(g_q * t0_3_q);
      fl_4_q    <= fl_3_q;
      fr_q      <= fl_3_q + aspan_3_q;
      // stage 5: slope times offset
      w0_5_q    <= w0_4_q;
      pl_q      <= PW'(fl_4_q * d_q[3]);
      pr_q      <= PW'(fr_q * d_q[3]);
      // stage 6: final phases, top bits pick the table entry
      idx_l_q   <= ph_l[PW-1 -: SB];
      idx_r_q   <= ph_r[PW-1 -: SB];
      for (int k = 1; k < NS; k++) begin
        d_q[k]    <= d_q[k-1];
        span_q[k] <= span_q[k-1];
        oor_q[k]  <= oor_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign d_o     = d_q[NS-1];
  assign span_o  = span_q[NS-1];
  assign idx_l_o = idx_l_q;
  assign idx_r_o = idx_r_q;
  assign oor_o   = oor_q[NS-1];

endmodule

// ===== design/ccsg_mix.sv =====
// ----------------------------------------------------------------------------
// Crossfade mixer
// Table lookup, weighting, sum, full-scale scaling and sign restore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsg_mix #(
  parameter int SINE_ENTRIES     = 1024,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [$clog2(SINE_ENTRIES)-1:0] idx_l_i,
  input  logic [$clog2(SINE_ENTRIES)-1:0] idx_r_i,
  input  logic [WEIGHT_FRAC_BITS-1:0]     wr_i,
  input  logic                            rem_nz_i,
  input  logic                            oor_i,
  output logic                            valid_o,
  output logic [15:0]                     sample_o,
  output logic                            oor_o
);

  localparam int SB = $clog2(SINE_ENTRIES);
  localparam int W  = WEIGHT_FRAC_BITS;
  localparam int SW = ccsg_pkg::SINE_W;
  localparam int PW = W + 18;   // signed weighted product and sum
  localparam int MW = W + 17;   // magnitude of the sum
  localparam int NS = 5;
  localparam logic [W:0] W_ONE = (W+1)'(1) << W;

  logic signed [SW-1:0] sine_rom [SINE_ENTRIES];
  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
    assign sine_rom[k] = ccsg_pkg::sine_entry(32'(k), SB);
  end

  logic [NS-1:0] v_q;
  logic          oor_q [NS];

  // wl = floor((span-d)*2^W/span) = 2^W - wr - (remainder != 0)
  logic [W:0] wl_d;
  assign wl_d = W_ONE - {1'b0, wr_i} - {{W{1'b0}}, rem_nz_i};

  logic [W:0]           wl_q;
  logic [W-1:0]         wr_q;
  logic signed [SW-1:0] sl_q, sr_q;
  logic signed [PW-1:0] pl_q, pr_q;
  logic signed [PW-1:0] m;
  logic [MW-1:0]        mag_q;
  logic                 neg_3_q, neg_4_q;
  logic [MW+14:0]       scaled;
  logic [15:0]          top;
  logic [14:0]          mag15_q;
  logic [15:0]          sample_q;

  assign m      = pl_q + pr_q;
  assign scaled = mag_q * ccsg_pkg::FULL_SCALE;
  assign top    = scaled[MW+14 -: 16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: weights and registered table reads
      wl_q     <= wl_d;
      wr_q     <= wr_i;
      sl_q     <= sine_rom[idx_l_i];
      sr_q     <= sine_rom[idx_r_i];
      oor_q[0] <= oor_i;
      // stage 2: weighted sines, operands widened to the product width
      pl_q     <= PW'($signed({1'b0, wl_q})) * PW'(sl_q);
      pr_q     <= PW'($signed({1'b0, wr_q})) * PW'(sr_q);
      // stage 3: sum to sign and magnitude
      neg_3_q  <= m[PW-1];
      mag_q    <= m[PW-1] ? MW'(-m) : MW'(m);
      // stage 4: times full scale, drop W+16 fraction bits, clip
      neg_4_q  <= neg_3_q;
      mag15_q  <= (top > {1'b0, ccsg_pkg::FULL_SCALE}) ? ccsg_pkg::FULL_SCALE : top[14:0];
      // stage 5: sign restore, out-of-range forces zero
      if (oor_q[3]) begin
        sample_q <= '0;
      end else begin
        sample_q <= neg_4_q ? -{1'b0, mag15_q} : {1'b0, mag15_q};
      end
      for (int k = 1; k < NS; k++) begin
        oor_q[k] <= oor_q[k-1];
      end
    end
  end

  assign valid_o  = v_q[NS-1];
  assign sample_o = sample_q;
  assign oor_o    = oor_q[NS-1];

endmodule

// ===== design/crossfaded_chirp_sample_generator.sv =====
// ----------------------------------------------------------------------------
// Crossfaded chirp sample generator
// Linear chirp, one 16-bit sample per sample index, piecewise crossfaded.
// ----------------------------------------------------------------------------
// Give a sample index t on the input stream and get back one sample of
// sin(2*pi*(a*t^2 + b*t)), where a (chirp_rate, 2^-48 turns/sample^2) and
// b (base_freq, 2^-32 turns/sample) are registers. The signal is split into
// segments of block_size samples, the last one clipped at total_length; in
// each segment two sines that start at the exact segment phase are blended
// linearly, one at the start slope and one at the chord slope, so every
// segment ends on the true phase. Indexes at or past total_length return 0
// with out_of_range set. The block takes one index per clock and gives one
// sample per clock, unless back-pressure on m_axis_tready stalls the pipe.
// Each index passes the bit-per-stage remainder divider on t, the phase
// multiplier chain, the bit-per-stage weight divider, the mixer and the
// output register. Write the registers only while no transfer is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "crossfaded_chirp_sample_generator_defines.svh"

module crossfaded_chirp_sample_generator #(
  parameter int MAX_SAMPLES      = 1048576,
  parameter int SINE_ENTRIES     = 1024,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [ccsg_pkg::ADDR_W-1:0]   cfg_addr_i,
  input  logic [ccsg_pkg::CFG_W-1:0]    cfg_data_i,
  // index stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // [19:0] sample_index
  // sample stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [15:0] sample
  output logic                          m_axis_tuser    // [0] out_of_range
);

  localparam int SB = $clog2(SINE_ENTRIES);
  localparam int W  = WEIGHT_FRAC_BITS;
  localparam int TW = ccsg_pkg::T_W;
  localparam int BW = ccsg_pkg::BS_W;
  localparam int LW = ccsg_pkg::LEN_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_SAMPLES);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [31:0]   chirp_rate_q;
  logic [31:0]   base_freq_q;
  logic [BW-1:0] block_size_q;
  logic [LW-1:0] total_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chirp_rate_q   <= ccsg_pkg::RST_CHIRP_RATE;
      base_freq_q    <= ccsg_pkg::RST_BASE_FREQ;
      block_size_q   <= ccsg_pkg::RST_BLOCK_SIZE;
      total_length_q <= ccsg_pkg::RST_TOTAL_LENGTH;
    end else if (cfg_we_i) begin
      case (ccsg_pkg::cfg_reg_e'(cfg_addr_i))
        ccsg_pkg::REG_CHIRP_RATE:   chirp_rate_q   <= cfg_data_i;
        ccsg_pkg::REG_BASE_FREQ:    base_freq_q    <= cfg_data_i;
        ccsg_pkg::REG_BLOCK_SIZE:   block_size_q   <= cfg_data_i[BW-1:0];
        ccsg_pkg::REG_TOTAL_LENGTH: total_length_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // Effective values: zero block size acts as one, length capped at capacity
  ccsg_pkg::cfg_t cfg;
  assign cfg.chirp_rate   = chirp_rate_q;
  assign cfg.base_freq    = base_freq_q;
  assign cfg.block_size   = (block_size_q == '0) ? BW'(1) : block_size_q;
  assign cfg.total_length = (total_length_q > MAX_LEN) ? MAX_LEN : total_length_q;

  // --------------------------------------------------------------------------
  // Pipeline advance: the whole pipe moves unless the skid slot is taken.
  // --------------------------------------------------------------------------
  logic skid_v_q;
  logic out_v_q;
  logic en;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  logic [TW-1:0] t_in;
  logic          oor_in;
  assign t_in   = s_axis_tdata[TW-1:0];
  assign oor_in = {1'b0, t_in} >= cfg.total_length;

  // Stage group 1: d = t mod block_size
  logic          dv1_v;
  logic [BW-1:0] dv1_rem;
  logic [TW:0]   dv1_pay;

  ccsg_div_pipe #(
    .NUM_W (TW),
    .DEN_W (BW),
    .PAY_W (TW + 1)
  ) u_seg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .num_i   (t_in),
    .rem_i   ('0),
    .den_i   (cfg.block_size),
    .pay_i   ({oor_in, t_in}),
    .valid_o (dv1_v),
    .quo_o   (),
    .rem_o   (dv1_rem),
    .pay_o   (dv1_pay)
  );

  // Stage group 2: segment bounds and both phases
  logic          ph_v;
  logic [BW-1:0] ph_d;
  logic [BW-1:0] ph_span;
  logic [SB-1:0] ph_idx_l;
  logic [SB-1:0] ph_idx_r;
  logic          ph_oor;

  ccsg_phase #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv1_v),
    .cfg_i   (cfg),
    .t_i     (dv1_pay[TW-1:0]),
    .d_i     (dv1_rem),
    .oor_i   (dv1_pay[TW]),
    .valid_o (ph_v),
    .d_o     (ph_d),
    .span_o  (ph_span),
    .idx_l_o (ph_idx_l),
    .idx_r_o (ph_idx_r),
    .oor_o   (ph_oor)
  );

  // Stage group 3: wr = floor(d * 2^W / span); d < span so W steps suffice
  logic            dv2_v;
  logic [W-1:0]    dv2_quo;
  logic [BW-1:0]   dv2_rem;
  logic [2*SB:0]   dv2_pay;

  ccsg_div_pipe #(
    .NUM_W (W),
    .DEN_W (BW),
    .PAY_W (2 * SB + 1)
  ) u_wgt_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ph_v),
    .num_i   ('0),
    .rem_i   (ph_d),
    .den_i   (ph_span),
    .pay_i   ({ph_oor, ph_idx_r, ph_idx_l}),
    .valid_o (dv2_v),
    .quo_o   (dv2_quo),
    .rem_o   (dv2_rem),
    .pay_o   (dv2_pay)
  );

  // Stage group 4: lookup, blend, scale
  logic        mx_v;
  logic [15:0] mx_sample;
  logic        mx_oor;

  ccsg_mix #(
    .SINE_ENTRIES     (SINE_ENTRIES),
    .WEIGHT_FRAC_BITS (W)
  ) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dv2_v),
    .idx_l_i  (dv2_pay[SB-1:0]),
    .idx_r_i  (dv2_pay[2*SB-1:SB]),
    .wr_i     (dv2_quo),
    .rem_nz_i (dv2_rem != '0),
    .oor_i    (dv2_pay[2*SB]),
    .valid_o  (mx_v),
    .sample_o (mx_sample),
    .oor_o    (mx_oor)
  );

  // --------------------------------------------------------------------------
  // Output register with one skid slot: a sample that leaves the pipe while the
  // output is stalled parks here, and the full slot then freezes the pipe.
  // --------------------------------------------------------------------------
  logic        pipe_xfer;
  logic [16:0] out_q;
  logic [16:0] skid_q;
  assign pipe_xfer = mx_v && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q  <= skid_v_q || pipe_xfer;
      skid_v_q <= 1'b0;
    end else if (pipe_xfer) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : {mx_oor, mx_sample};
    end else if (pipe_xfer) begin
      skid_q <= {mx_oor, mx_sample};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q[15:0];
  assign m_axis_tuser  = out_q[16];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CCSG_ASSERT(a_skid_needs_out, skid_v_q |-> out_v_q, "skid slot full with empty output")
  `CCSG_ASSERT(a_oor_zero, (out_v_q && out_q[16]) |-> (out_q[15:0] == '0), "out of range sample not zero")
  `CCSG_NEVER(a_no_min_code, out_v_q && (out_q[15:0] == 16'h8000), "sample beyond full scale")
  `CCSG_ASSERT(a_skid_fill, ($past(out_v_q && !m_axis_tready && pipe_xfer)) |-> skid_v_q, "stalled transfer dropped")

endmodule
